// ===== hw/rtl/rlm_pkg.sv =====
// ----------------------------------------------------------------------------
// rlm_pkg
// Shared sizes, opcodes and payload types of the rolling average limit monitor.
// ----------------------------------------------------------------------------
package rlm_pkg;

   localparam int SENSORS     = 10;
   localparam int WINDOW      = 5;
   localparam int SAMPLE_BITS = 16;

   localparam int INDEX_BITS  = 4;
   localparam int COUNT_BITS  = 5;
   localparam int THRESH_BITS = 5;
   localparam int TOTAL_BITS  = 32;

   localparam int SUM_BITS    = SAMPLE_BITS + 3;
   localparam int SCALE_BITS  = SAMPLE_BITS + 4;
   localparam int SENSOR_AW   = (SENSORS > 1) ? $clog2(SENSORS) : 1;
   localparam int SLOT_BITS   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int WARM_BITS   = $clog2(WINDOW + 1);
   localparam int HIST_DEPTH  = WINDOW * SENSORS;
   localparam int HIST_AW     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef struct packed {
      logic [TOTAL_BITS-1:0]  row_number;
      logic [COUNT_BITS-1:0]  out_of_bounds_count;
      logic                   anomaly;
      logic [TOTAL_BITS-1:0]  anomaly_total;
   } rsp_type;

   typedef struct packed {
      logic                          valid;
      logic                          opcode;
      logic [SENSOR_AW-1:0]          sensor;
      logic signed [SAMPLE_BITS-1:0] sample_value;
      logic signed [SAMPLE_BITS-1:0] limit_low;
      logic signed [SAMPLE_BITS-1:0] limit_high;
      logic                          sub;
      logic                          fwd;
      logic                          close;
      logic [HIST_AW-1:0]            addr;
   } s1_type;

   typedef struct packed {
      logic valid;
      logic oob;
      logic close;
   } s2_type;

endpackage

// ===== hw/rtl/rlm_req_if.sv =====
// ----------------------------------------------------------------------------
// rlm_req_if
// Request channel: limit loads and sensor samples.
// ----------------------------------------------------------------------------
interface rlm_req_if;

   logic                                   valid;
   logic                                   ready;
   logic                                   opcode;
   logic [rlm_pkg::INDEX_BITS-1:0]         sensor_index;
   logic signed [rlm_pkg::SAMPLE_BITS-1:0] sample_value;
   logic signed [rlm_pkg::SAMPLE_BITS-1:0] limit_low;
   logic signed [rlm_pkg::SAMPLE_BITS-1:0] limit_high;

   modport source (
      output valid, opcode, sensor_index, sample_value, limit_low, limit_high,
      input  ready
   );

   modport sink (
      input  valid, opcode, sensor_index, sample_value, limit_low, limit_high,
      output ready
   );

endinterface

// ===== hw/rtl/rlm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rlm_rsp_if
// Response channel: one row summary per evaluated row.
// ----------------------------------------------------------------------------
interface rlm_rsp_if;

   logic                            valid;
   logic                            ready;
   logic [rlm_pkg::TOTAL_BITS-1:0]  row_number;
   logic [rlm_pkg::COUNT_BITS-1:0]  out_of_bounds_count;
   logic                            anomaly;
   logic [rlm_pkg::TOTAL_BITS-1:0]  anomaly_total;

   modport source (
      output valid, row_number, out_of_bounds_count, anomaly, anomaly_total,
      input  ready
   );

   modport sink (
      input  valid, row_number, out_of_bounds_count, anomaly, anomaly_total,
      output ready
   );

endinterface

// ===== hw/rtl/rlm_csr_if.sv =====
// ----------------------------------------------------------------------------
// rlm_csr_if
// Control register write channel carrying the anomaly threshold.
// ----------------------------------------------------------------------------
interface rlm_csr_if;

   logic                            valid;
   logic                            ready;
   logic [rlm_pkg::THRESH_BITS-1:0] anomaly_threshold;

   modport source (
      output valid, anomaly_threshold,
      input  ready
   );

   modport sink (
      input  valid, anomaly_threshold,
      output ready
   );

endinterface

// ===== hw/rtl/rolling_average_limit_monitor.sv =====
// ----------------------------------------------------------------------------
// rolling_average_limit_monitor
// Moving average range check over a row of sensors with row anomaly counting.
// ----------------------------------------------------------------------------
// req_ch carries one request per handshake: opcode 0 loads the low and high
// limits of one sensor, opcode 1 delivers one sample; samples of a row come
// in ascending sensor order and the last sensor closes the row.
// rsp_ch returns one summary per closed row once a full window of rows has
// been seen: row number, out of bounds count, anomaly flag, anomaly total.
// csr_ch writes the anomaly threshold; it is always ready, and the user must
// write it only while the block is idle; the block itself does not enforce this.
// A request is taken every cycle while req_ch.ready is high. The summary of a
// closing sample passes the capture stage, the window sum update and the row
// count update into the output stage before it is valid on rsp_ch.
// The output stage plus one skid entry let requests keep flowing while a
// summary waits; req_ch.ready drops only when both are full.
// Reset clears limits, sums, row and anomaly counters, the threshold and the
// output stage; the sample history holds no data until written.
// ----------------------------------------------------------------------------
module rolling_average_limit_monitor (
   input  logic      clock,
   input  logic      reset,
   rlm_req_if.sink   req_ch,
   rlm_rsp_if.source rsp_ch,
   rlm_csr_if.sink   csr_ch
);

   localparam logic [rlm_pkg::TOTAL_BITS-1:0] SAT_MAX  = '1;
   localparam logic [rlm_pkg::COUNT_BITS-1:0] CNT_MAX  = '1;
   localparam logic signed [rlm_pkg::SCALE_BITS-1:0] WINDOW_S =
      rlm_pkg::SCALE_BITS'(rlm_pkg::WINDOW);

   logic [rlm_pkg::THRESH_BITS-1:0]        thresh_ff;

   logic [rlm_pkg::SLOT_BITS-1:0]          slot_ff;
   logic [rlm_pkg::WARM_BITS-1:0]          warm_ff;

   logic signed [rlm_pkg::SAMPLE_BITS-1:0] hist_mem [rlm_pkg::HIST_DEPTH];
   logic signed [rlm_pkg::SAMPLE_BITS-1:0] hist_rd_ff;
   logic signed [rlm_pkg::SAMPLE_BITS-1:0] fwd_data_ff;

   logic signed [rlm_pkg::SUM_BITS-1:0]    sum_tab_ff  [rlm_pkg::SENSORS];
   logic signed [rlm_pkg::SCALE_BITS-1:0]  low_tab_ff  [rlm_pkg::SENSORS];
   logic signed [rlm_pkg::SCALE_BITS-1:0]  high_tab_ff [rlm_pkg::SENSORS];

   rlm_pkg::s1_type s1_ff;
   rlm_pkg::s2_type s2_ff;

   logic [rlm_pkg::TOTAL_BITS-1:0] rows_ff;
   logic [rlm_pkg::TOTAL_BITS-1:0] total_ff;
   logic [rlm_pkg::COUNT_BITS-1:0] viol_ff;

   rlm_pkg::rsp_type out_ff;
   rlm_pkg::rsp_type skid_ff;
   logic             out_valid_ff;
   logic             skid_valid_ff;

   logic                                   run;
   logic                                   req_accept;
   logic                                   idx_ok;
   logic                                   close_in;
   logic [rlm_pkg::SENSOR_AW-1:0]          sensor_in;
   logic [rlm_pkg::HIST_AW-1:0]            rd_addr;

   logic signed [rlm_pkg::SAMPLE_BITS-1:0] old_val;
   logic signed [rlm_pkg::SUM_BITS-1:0]    sum_in;
   logic signed [rlm_pkg::SCALE_BITS-1:0]  low_scaled;
   logic signed [rlm_pkg::SCALE_BITS-1:0]  high_scaled;
   logic                                   oob;

   logic [rlm_pkg::COUNT_BITS-1:0]         cnt_in;
   logic [rlm_pkg::TOTAL_BITS-1:0]         row_no;
   logic                                   emit;
   logic                                   anom;
   logic                                   push;
   logic                                   pop;
   rlm_pkg::rsp_type                       result_in;

   // front end: capture and history address
   assign run        = !skid_valid_ff;
   assign req_accept = req_ch.valid && run;
   assign idx_ok     = {1'b0, req_ch.sensor_index} <
                       (rlm_pkg::INDEX_BITS + 1)'(rlm_pkg::SENSORS);
   assign sensor_in  = req_ch.sensor_index[rlm_pkg::SENSOR_AW-1:0];
   assign close_in   = (req_ch.opcode == rlm_pkg::OP_SAMPLE) &&
                       (req_ch.sensor_index ==
                        rlm_pkg::INDEX_BITS'(rlm_pkg::SENSORS - 1));
   assign rd_addr    = rlm_pkg::HIST_AW'(slot_ff) *
                       rlm_pkg::HIST_AW'(rlm_pkg::SENSORS) +
                       rlm_pkg::HIST_AW'(sensor_in);

   assign req_ch.ready = run;
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= '0;
      end else if (csr_ch.valid) begin
         thresh_ff <= csr_ch.anomaly_threshold;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         warm_ff <= '0;
      end else if (req_accept && idx_ok && close_in) begin
         slot_ff <= (slot_ff == rlm_pkg::SLOT_BITS'(rlm_pkg::WINDOW - 1)) ?
                    '0 : slot_ff + 1'b1;
         if (warm_ff < rlm_pkg::WARM_BITS'(rlm_pkg::WINDOW)) begin
            warm_ff <= warm_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         hist_rd_ff  <= hist_mem[rd_addr];
         fwd_data_ff <= s1_ff.sample_value;
      end
      if (run && s1_ff.valid && s1_ff.opcode == rlm_pkg::OP_SAMPLE) begin
         hist_mem[s1_ff.addr] <= s1_ff.sample_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else if (run) begin
         s1_ff.valid <= req_accept && idx_ok;
      end
      if (req_accept) begin
         s1_ff.opcode       <= req_ch.opcode;
         s1_ff.sensor       <= sensor_in;
         s1_ff.sample_value <= req_ch.sample_value;
         s1_ff.limit_low    <= req_ch.limit_low;
         s1_ff.limit_high   <= req_ch.limit_high;
         s1_ff.sub          <= warm_ff >= rlm_pkg::WARM_BITS'(rlm_pkg::WINDOW);
         s1_ff.fwd          <= s1_ff.valid && s1_ff.opcode == rlm_pkg::OP_SAMPLE &&
                               s1_ff.addr == rd_addr;
         s1_ff.close        <= close_in;
         s1_ff.addr         <= rd_addr;
      end
   end

   // window sum update and limit check
   assign old_val     = s1_ff.fwd ? fwd_data_ff : hist_rd_ff;
   assign sum_in      = sum_tab_ff[s1_ff.sensor] +
                        rlm_pkg::SUM_BITS'(s1_ff.sample_value) -
                        (s1_ff.sub ? rlm_pkg::SUM_BITS'(old_val) : '0);
   assign low_scaled  = rlm_pkg::SCALE_BITS'(rlm_pkg::SCALE_BITS'(s1_ff.limit_low) *
                                             WINDOW_S);
   assign high_scaled = rlm_pkg::SCALE_BITS'(rlm_pkg::SCALE_BITS'(s1_ff.limit_high) *
                                             WINDOW_S);
   assign oob         = (rlm_pkg::SCALE_BITS'(sum_in) < low_tab_ff[s1_ff.sensor]) ||
                        (rlm_pkg::SCALE_BITS'(sum_in) > high_tab_ff[s1_ff.sensor]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rlm_pkg::SENSORS; i++) begin
            sum_tab_ff[i]  <= '0;
            low_tab_ff[i]  <= '0;
            high_tab_ff[i] <= '0;
         end
      end else if (run && s1_ff.valid) begin
         if (s1_ff.opcode == rlm_pkg::OP_SAMPLE) begin
            sum_tab_ff[s1_ff.sensor] <= sum_in;
         end else begin
            low_tab_ff[s1_ff.sensor]  <= low_scaled;
            high_tab_ff[s1_ff.sensor] <= high_scaled;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
      end else if (run) begin
         s2_ff.valid <= s1_ff.valid && s1_ff.opcode == rlm_pkg::OP_SAMPLE;
      end
      if (run) begin
         s2_ff.oob   <= oob;
         s2_ff.close <= s1_ff.close;
      end
   end

   // row counting and summary
   assign cnt_in = (s2_ff.oob && viol_ff != CNT_MAX) ? viol_ff + 1'b1 : viol_ff;
   assign row_no = (rows_ff != SAT_MAX) ? rows_ff + 1'b1 : rows_ff;
   assign emit   = row_no >= rlm_pkg::TOTAL_BITS'(rlm_pkg::WINDOW);
   assign anom   = cnt_in > rlm_pkg::COUNT_BITS'(thresh_ff);
   assign push   = run && s2_ff.valid && s2_ff.close && emit;
   assign pop    = out_valid_ff && rsp_ch.ready;

   always_comb begin
      result_in.row_number          = row_no;
      result_in.out_of_bounds_count = cnt_in;
      result_in.anomaly             = anom;
      result_in.anomaly_total       = (anom && total_ff != SAT_MAX) ?
                                      total_ff + 1'b1 : total_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= '0;
         total_ff <= '0;
         viol_ff  <= '0;
      end else if (run && s2_ff.valid) begin
         if (s2_ff.close) begin
            rows_ff <= row_no;
            viol_ff <= '0;
            if (emit) begin
               total_ff <= result_in.anomaly_total;
            end
         end else begin
            viol_ff <= cnt_in;
         end
      end
   end

   // output stage with one skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end else if (push) begin
            out_ff <= result_in;
         end else begin
            out_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (out_valid_ff) begin
            skid_ff       <= result_in;
            skid_valid_ff <= 1'b1;
         end else begin
            out_ff       <= result_in;
            out_valid_ff <= 1'b1;
         end
      end
   end

   assign rsp_ch.valid               = out_valid_ff;
   assign rsp_ch.row_number          = out_ff.row_number;
   assign rsp_ch.out_of_bounds_count = out_ff.out_of_bounds_count;
   assign rsp_ch.anomaly             = out_ff.anomaly;
   assign rsp_ch.anomaly_total       = out_ff.anomaly_total;

endmodule

// ===== hw/rtl/rlm_checker.sv =====
// ----------------------------------------------------------------------------
// rlm_checker
// Port level checks of the rolling average limit monitor, bound to the top.
// ----------------------------------------------------------------------------
module rlm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [rlm_pkg::TOTAL_BITS-1:0]  row_number,
   input logic                            anomaly,
   input logic [rlm_pkg::TOTAL_BITS-1:0]  anomaly_total
);

   // no summary straight out of reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("summary valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(row_number) &&
                                  $stable(anomaly_total))
      else $error("stalled summary changed");

   // summaries only once a full window of rows has closed
   a_row_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> row_number >= rlm_pkg::TOTAL_BITS'(rlm_pkg::WINDOW))
      else $error("summary before window filled");

   a_total_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && anomaly |-> anomaly_total != '0)
      else $error("anomalous row not counted");

   // requests only stall while a summary is pending
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

endmodule

bind rolling_average_limit_monitor rlm_checker u_rlm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .row_number    (rsp_ch.row_number),
   .anomaly       (rsp_ch.anomaly),
   .anomaly_total (rsp_ch.anomaly_total)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rolling average limit monitor. Requests are
// built as sensor rows (clean, noisy, with repeats, dense and, once every
// history slot is filled, with gaps), driven through a queue under several
// idle and stall profiles, and each row summary is checked against an
// in-bench model of the window sums, limit tables and row counters.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int Q_MAX        = 2 ** (rlm_pkg::SAMPLE_BITS - 1) - 1;
   localparam int Q_MIN        = -(2 ** (rlm_pkg::SAMPLE_BITS - 1));
   localparam int INDEX_MAX    = 2 ** rlm_pkg::INDEX_BITS - 1;
   localparam int THRESH_MAX   = 2 ** rlm_pkg::THRESH_BITS - 1;
   localparam int COUNT_MAX    = 2 ** rlm_pkg::COUNT_BITS - 1;
   localparam int PHASES       = 5;
   localparam int PHASE_ITEMS  = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int QUIET_LIMIT  = 4000;

   typedef struct packed {
      logic                                   opcode;
      logic [rlm_pkg::INDEX_BITS-1:0]         sensor_index;
      logic signed [rlm_pkg::SAMPLE_BITS-1:0] sample_value;
      logic signed [rlm_pkg::SAMPLE_BITS-1:0] limit_low;
      logic signed [rlm_pkg::SAMPLE_BITS-1:0] limit_high;
   } monitor_req_type;

   logic clock = 1'b0;
   logic reset;

   rlm_req_if req_ch ();
   rlm_rsp_if rsp_ch ();
   rlm_csr_if csr_ch ();

   rolling_average_limit_monitor dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // stimulus and expectations
   monitor_req_type  pending_requests [$];
   rlm_pkg::rsp_type expected_summaries [$];
   monitor_req_type  next_req;
   monitor_req_type  seen_req;
   rlm_pkg::rsp_type wanted_summary;

   int          send_idle_pct;
   int          recv_stall_pct;
   int          counted_items;
   int          rows_built;
   int          sensor_level [rlm_pkg::SENSORS];
   int          mismatches;
   int unsigned quiet_cycles;
   logic        req_taken;
   logic        csr_taken;

   // model state
   logic signed [rlm_pkg::SAMPLE_BITS-1:0] sample_hist [rlm_pkg::WINDOW][rlm_pkg::SENSORS];
   logic [rlm_pkg::SUM_BITS-1:0]           window_sums [rlm_pkg::SENSORS];
   logic signed [rlm_pkg::SAMPLE_BITS-1:0] low_tab [rlm_pkg::SENSORS];
   logic signed [rlm_pkg::SAMPLE_BITS-1:0] high_tab [rlm_pkg::SENSORS];
   int                                     hist_slot;
   logic [rlm_pkg::TOTAL_BITS-1:0]         rows_closed;
   logic [rlm_pkg::COUNT_BITS-1:0]         row_oob_count;
   logic [rlm_pkg::TOTAL_BITS-1:0]         anomalous_rows;
   logic [rlm_pkg::THRESH_BITS-1:0]        threshold_setting;

   int send_idle_by_phase [PHASES]  = '{0, 85, 0, 22, 0};
   int recv_stall_by_phase [PHASES] = '{0, 0, 85, 22, 0};

   function automatic logic [rlm_pkg::SUM_BITS-1:0] widen(
      input logic signed [rlm_pkg::SAMPLE_BITS-1:0] v);
      return {{(rlm_pkg::SUM_BITS - rlm_pkg::SAMPLE_BITS){v[rlm_pkg::SAMPLE_BITS-1]}}, v};
   endfunction

   function automatic int clamp_q88(input int v);
      if (v > Q_MAX) begin
         return Q_MAX;
      end else if (v < Q_MIN) begin
         return Q_MIN;
      end
      return v;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
      mismatches++;
   endtask

   task automatic track_request(input monitor_req_type r);
      logic signed [rlm_pkg::SAMPLE_BITS-1:0] prev;
      longint                                 sum_val;
      logic                                   oob;
      logic                                   anom;
      logic [rlm_pkg::TOTAL_BITS-1:0]         row_no;
      rlm_pkg::rsp_type                       summary;
      int                                     s;
      s = r.sensor_index;
      if (s >= rlm_pkg::SENSORS) return;
      if (r.opcode == rlm_pkg::OP_LOAD) begin
         low_tab[s]  = r.limit_low;
         high_tab[s] = r.limit_high;
         return;
      end
      prev = (rows_closed >= rlm_pkg::WINDOW) ? sample_hist[hist_slot][s] : '0;
      window_sums[s] = window_sums[s] + widen(r.sample_value) - widen(prev);
      sample_hist[hist_slot][s] = r.sample_value;
      sum_val = $signed(window_sums[s]);
      oob = (sum_val < rlm_pkg::WINDOW * longint'(low_tab[s])) ||
            (sum_val > rlm_pkg::WINDOW * longint'(high_tab[s]));
      if (oob && row_oob_count != COUNT_MAX) row_oob_count++;
      if (s != rlm_pkg::SENSORS - 1) return;
      // row closes
      row_no = (rows_closed != '1) ? rows_closed + 1 : rows_closed;
      if (row_no >= rlm_pkg::WINDOW) begin
         anom = row_oob_count > threshold_setting;
         if (anom && anomalous_rows != '1) anomalous_rows++;
         summary.row_number          = row_no;
         summary.out_of_bounds_count = row_oob_count;
         summary.anomaly             = anom;
         summary.anomaly_total       = anomalous_rows;
         expected_summaries.push_back(summary);
      end
      rows_closed   = row_no;
      row_oob_count = '0;
      hist_slot     = (hist_slot + 1) % rlm_pkg::WINDOW;
   endtask

   // request builders
   task automatic push_request(input logic op, input int sensor, input int sample,
                               input int low, input int high);
      monitor_req_type r;
      r.opcode       = op;
      r.sensor_index = rlm_pkg::INDEX_BITS'(sensor);
      r.sample_value = rlm_pkg::SAMPLE_BITS'(sample);
      r.limit_low    = rlm_pkg::SAMPLE_BITS'(low);
      r.limit_high   = rlm_pkg::SAMPLE_BITS'(high);
      pending_requests.push_back(r);
      if (sensor < rlm_pkg::SENSORS) counted_items++;
      if (op == rlm_pkg::OP_SAMPLE && sensor == rlm_pkg::SENSORS - 1) rows_built++;
   endtask

   task automatic queue_load(input int s);
      int level;
      int margin;
      level = int'($urandom_range(0, 16384)) - 8192;
      margin = $urandom_range(0, 1024);
      sensor_level[s] = level;
      case ($urandom_range(0, 9))
         0: push_request(rlm_pkg::OP_LOAD, s, 0, int'($urandom), int'($urandom));
         1: push_request(rlm_pkg::OP_LOAD, s, 0, Q_MIN, Q_MAX);
         default: push_request(rlm_pkg::OP_LOAD, s, 0, clamp_q88(level - margin),
                               clamp_q88(level + margin));
      endcase
   endtask

   task automatic queue_sample(input int s, input int spread);
      int v;
      if ($urandom_range(0, 9) == 0) begin
         v = int'($urandom);
      end else begin
         v = clamp_q88(sensor_level[s] + int'($urandom_range(0, 2 * spread)) - spread);
      end
      push_request(rlm_pkg::OP_SAMPLE, s, v, int'($urandom), int'($urandom));
   endtask

   task automatic queue_noise();
      if ($urandom_range(0, 2) == 0) begin
         queue_load($urandom_range(0, rlm_pkg::SENSORS - 1));
      end else begin
         // index past the last sensor, dropped by the block
         push_request($urandom_range(0, 1) ? rlm_pkg::OP_SAMPLE : rlm_pkg::OP_LOAD,
                      $urandom_range(rlm_pkg::SENSORS, INDEX_MAX),
                      int'($urandom), int'($urandom), int'($urandom));
      end
   endtask

   task automatic build_row();
      int  kind;
      int  spread;
      int  reps;
      bit  warm;
      // gaps only once every history slot has been written
      warm = rows_built < rlm_pkg::WINDOW;
      kind = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
         0: spread = 16;
         1: spread = 256;
         2: spread = 1024;
         default: spread = 4096;
      endcase
      if (kind < 8) spread = 8192;
      for (int s = 0; s < rlm_pkg::SENSORS; s++) begin
         if (!warm && kind >= 90 && $urandom_range(0, 99) < 30) continue;
         if (kind >= 60 && kind < 90 && $urandom_range(0, 4) == 0) queue_noise();
         reps = 1;
         if (kind < 8) begin
            reps = $urandom_range(3, 5);
         end else if (kind >= 75 && kind < 90) begin
            reps = $urandom_range(1, 2);
         end
         // a repeated last sensor closes extra rows, so none while warming up
         if (warm && s == rlm_pkg::SENSORS - 1) reps = 1;
         repeat (reps) queue_sample(s, spread);
      end
   endtask

   task automatic queue_directed();
      push_request(rlm_pkg::OP_LOAD, 0, 0, Q_MIN, Q_MAX);
      push_request(rlm_pkg::OP_LOAD, 1, 0, Q_MAX, Q_MIN);
      push_request(rlm_pkg::OP_LOAD, 2, 0, 0, 0);
      for (int s = 3; s < rlm_pkg::SENSORS; s++) begin
         push_request(rlm_pkg::OP_LOAD, s, 0, -256, 256);
      end
      push_request(rlm_pkg::OP_LOAD, INDEX_MAX, -1, -1, -1);
      push_request(rlm_pkg::OP_LOAD, rlm_pkg::SENSORS, 0, 16'h5555, 16'hAAAA);
      push_request(rlm_pkg::OP_SAMPLE, rlm_pkg::SENSORS + 2, -1, 0, 0);
      push_request(rlm_pkg::OP_SAMPLE, INDEX_MAX, Q_MAX, 0, 0);
      push_request(rlm_pkg::OP_SAMPLE, 0, Q_MIN, 0, 0);
      push_request(rlm_pkg::OP_SAMPLE, 1, Q_MAX, 0, 0);
      push_request(rlm_pkg::OP_SAMPLE, 2, 0, 0, 0);
      push_request(rlm_pkg::OP_SAMPLE, 3, 16'h5555, 0, 0);
      push_request(rlm_pkg::OP_SAMPLE, 3, 16'hAAAA, 0, 0);
      push_request(rlm_pkg::OP_SAMPLE, 4, -1, 0, 0);
      // limits change part way through the row
      push_request(rlm_pkg::OP_LOAD, 5, 0, Q_MIN, Q_MAX);
      push_request(rlm_pkg::OP_SAMPLE, 5, 100, 0, 0);
      for (int s = 6; s < rlm_pkg::SENSORS - 1; s++) queue_sample(s, 256);
      push_request(rlm_pkg::OP_SAMPLE, rlm_pkg::SENSORS - 1, 1, 0, 0);
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_requests.size() != 0 || req_ch.valid || expected_summaries.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input int value);
      @(negedge clock);
      csr_ch.valid             <= 1'b1;
      csr_ch.anomaly_threshold <= rlm_pkg::THRESH_BITS'(value);
      do @(negedge clock);
      while (!csr_taken);
      csr_ch.valid <= 1'b0;
   endtask

   // request driver and response ready
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_req = pending_requests.pop_front();
            req_ch.valid        <= 1'b1;
            req_ch.opcode       <= next_req.opcode;
            req_ch.sensor_index <= next_req.sensor_index;
            req_ch.sample_value <= next_req.sample_value;
            req_ch.limit_low    <= next_req.limit_low;
            req_ch.limit_high   <= next_req.limit_high;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // monitor: handshakes, prediction and checking
   always @(posedge clock) begin
      req_taken = 1'b0;
      csr_taken = 1'b0;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_summaries.size() == 0) begin
               report_mismatch("unexpected summary, row_number", rsp_ch.row_number, '0);
            end else begin
               wanted_summary = expected_summaries.pop_front();
               if (rsp_ch.row_number !== wanted_summary.row_number)
                  report_mismatch("row_number", rsp_ch.row_number,
                                  wanted_summary.row_number);
               if (rsp_ch.out_of_bounds_count !== wanted_summary.out_of_bounds_count)
                  report_mismatch("out_of_bounds_count",
                                  32'(rsp_ch.out_of_bounds_count),
                                  32'(wanted_summary.out_of_bounds_count));
               if (rsp_ch.anomaly !== wanted_summary.anomaly)
                  report_mismatch("anomaly", 32'(rsp_ch.anomaly),
                                  32'(wanted_summary.anomaly));
               if (rsp_ch.anomaly_total !== wanted_summary.anomaly_total)
                  report_mismatch("anomaly_total", rsp_ch.anomaly_total,
                                  wanted_summary.anomaly_total);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            req_taken = 1'b1;
            seen_req.opcode       = req_ch.opcode;
            seen_req.sensor_index = req_ch.sensor_index;
            seen_req.sample_value = req_ch.sample_value;
            seen_req.limit_low    = req_ch.limit_low;
            seen_req.limit_high   = req_ch.limit_high;
            track_request(seen_req);
         end
         if (csr_ch.valid && csr_ch.ready) begin
            csr_taken = 1'b1;
            threshold_setting = csr_ch.anomaly_threshold;
         end
      end
      if (req_taken || csr_taken || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
   end

   // watchdog
   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(negedge clock);
      $display("Verification failed");
      $finish;
   end

   initial begin
      int next_thr;
      reset                    = 1'b1;
      req_ch.valid             = 1'b0;
      req_ch.opcode            = rlm_pkg::OP_LOAD;
      req_ch.sensor_index      = '0;
      req_ch.sample_value      = '0;
      req_ch.limit_low         = '0;
      req_ch.limit_high        = '0;
      rsp_ch.ready             = 1'b0;
      csr_ch.valid             = 1'b0;
      csr_ch.anomaly_threshold = '0;
      send_idle_pct            = 0;
      recv_stall_pct           = 0;
      counted_items            = 0;
      rows_built               = 0;
      mismatches               = 0;
      quiet_cycles             = 0;
      req_taken                = 1'b0;
      csr_taken                = 1'b0;
      hist_slot                = 0;
      rows_closed              = '0;
      row_oob_count            = '0;
      anomalous_rows           = '0;
      threshold_setting        = '0;
      for (int s = 0; s < rlm_pkg::SENSORS; s++) begin
         window_sums[s]  = '0;
         low_tab[s]      = '0;
         high_tab[s]     = '0;
         sensor_level[s] = 0;
         for (int w = 0; w < rlm_pkg::WINDOW; w++) sample_hist[w][s] = '0;
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_threshold(0);
      queue_directed();
      for (int ph = 0; ph < PHASES; ph++) begin
         send_idle_pct  = send_idle_by_phase[ph];
         recv_stall_pct = recv_stall_by_phase[ph];
         next_thr = counted_items;
         while (counted_items - next_thr < PHASE_ITEMS) build_row();
         wait_drained();
         if (ph != PHASES - 1) begin
            next_thr = (ph == 0) ? 16 : (ph == 1) ? THRESH_MAX : $urandom_range(0, 16);
            write_threshold(next_thr);
         end
      end

      if (mismatches == 0 && expected_summaries.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
